### hw/rtl/cse_pkg.sv
// ----------------------------------------------------------------------------
// cse_pkg
// Shared widths and the controller-to-datapath command for the cosine
// similarity engine.
// ----------------------------------------------------------------------------
package cse_pkg;

    localparam int ElemW  = 16;
    localparam int DotW   = 44;
    localparam int MagW   = 43;
    localparam int ProdW  = 2 * MagW;      // mag_a * mag_b
    localparam int DsqW   = 2 * DotW;      // |dot|^2
    localparam int WideW  = 120;           // root search arithmetic
    localparam int QW     = 16;
    localparam int CntW   = 6;
    localparam int MulLast = DotW - 1;     // last shift-add step

    typedef struct packed {
        logic            load;      // capture input beat
        logic            prod;      // form element products
        logic            acc;       // saturating accumulate
        logic            mul_init;
        logic            mul_step;
        logic            srt_init;
        logic            srt_a;     // candidate increment
        logic            srt_b;     // compare and commit bit
        logic            finish;    // load result, clear accumulators
        logic [CntW-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic last;
    } t_stat;

endpackage

### hw/rtl/cse_ctrl.sv
// ----------------------------------------------------------------------------
// cse_ctrl
// Sequencer: accept, product, accumulate, then on a last beat the shift-add
// products and the bit-by-bit root search, then result hand-off.
// ----------------------------------------------------------------------------
module cse_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    output logic          o_valid,
    input  logic          i_ready,
    input  cse_pkg::t_stat i_stat,
    output cse_pkg::t_cmd  o_cmd
);
    import cse_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_PROD = 7'b0000010,
        S_ACC  = 7'b0000100,
        S_MUL  = 7'b0001000,
        S_SRTA = 7'b0010000,
        S_SRTB = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    t_state          r_state, n_state;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic            r_ovalid, n_ovalid;
    logic            w_free;

    assign w_free  = !r_ovalid || i_ready;
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ovalid;

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_ovalid = r_ovalid && !i_ready;
        o_cmd    = '0;
        o_cmd.idx = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_PROD;
                end
            end
            S_PROD: begin
                o_cmd.prod = 1'b1;
                n_state    = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                if (i_stat.last) begin
                    n_state = S_MUL;
                    n_cnt   = '0;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_MUL: begin
                o_cmd.mul_init = (r_cnt == '0);
                o_cmd.mul_step = (r_cnt != '0);
                o_cmd.idx      = r_cnt - CntW'(1);
                if (r_cnt == CntW'(MulLast + 1)) begin
                    n_state = S_SRTA;
                    n_cnt   = CntW'(QW - 1);
                end else begin
                    n_cnt = r_cnt + CntW'(1);
                end
                if (r_cnt == CntW'(MulLast + 1)) o_cmd.srt_init = 1'b1;
            end
            S_SRTA: begin
                o_cmd.srt_a = 1'b1;
                n_state     = S_SRTB;
            end
            S_SRTB: begin
                o_cmd.srt_b = 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_SRTA;
                    n_cnt   = r_cnt - CntW'(1);
                end
            end
            S_DONE: begin
                if (w_free) begin
                    o_cmd.finish = 1'b1;
                    n_ovalid     = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

    a_accept_to_prod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == S_PROD))
        else $error("accepted beat did not start product step");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> (!r_ovalid || i_ready))
        else $error("result loaded over a pending result");
    a_mul_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_cnt <= CntW'(MulLast + 1)))
        else $error("shift-add counter overran");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> (r_state == S_IDLE && r_ovalid))
        else $error("result hand-off did not return to idle");
endmodule

### hw/rtl/cse_dp.sv
// ----------------------------------------------------------------------------
// cse_dp
// Datapath: saturating accumulators, serial shift-add multipliers and a
// restoring square-ratio search for the Q1.15 result.
// ----------------------------------------------------------------------------
module cse_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  cse_pkg::t_cmd                i_cmd,
    output cse_pkg::t_stat               o_stat,
    input  logic signed [cse_pkg::ElemW-1:0] i_elem_a,
    input  logic signed [cse_pkg::ElemW-1:0] i_elem_b,
    input  logic                         i_last,
    input  logic                         i_cfg_we,
    input  logic [cse_pkg::ElemW-1:0]    i_cfg_floor,
    output logic signed [cse_pkg::ElemW-1:0] o_similarity,
    output logic                         o_degenerate
);
    import cse_pkg::*;

    logic signed [ElemW-1:0] r_a, r_b;
    logic                    r_last;
    logic [ElemW-1:0]        r_floor;
    logic [2*ElemW-1:0]      r_fsq;
    logic signed [2*ElemW-1:0] r_pab, r_paa, r_pbb;
    logic signed [DotW-1:0]  r_dot;
    logic [MagW-1:0]         r_maga, r_magb;
    logic [DotW-1:0]         r_mdot;
    logic [ProdW-1:0]        r_p;
    logic [DsqW-1:0]         r_d;
    logic [WideW-1:0]        r_s, r_t, r_u;
    logic [QW-1:0]           r_q;
    logic                    r_degen;

    logic signed [DotW:0]    w_dsum;
    logic [MagW:0]           w_asum, w_bsum;
    logic [WideW-1:0]        w_pw, w_dd, w_cand;
    logic [3:0]              w_k;
    logic [QW-1:0]           w_pos, w_neg;

    assign o_stat.last = r_last;
    assign w_k    = i_cmd.idx[3:0];
    assign w_dsum = {r_dot[DotW-1], r_dot} + (DotW+1)'(r_pab);
    assign w_asum = {1'b0, r_maga} + (MagW+1)'(r_paa[2*ElemW-2:0]);
    assign w_bsum = {1'b0, r_magb} + (MagW+1)'(r_pbb[2*ElemW-2:0]);
    assign w_pw   = WideW'(r_p);
    // |dot|^2 scaled by 2^30
    assign w_dd   = WideW'({r_d, 30'b0});
    assign w_cand = r_s + r_u;
    // q >= 32768 only when the ratio magnitude reaches 1.0 or beyond
    assign w_pos  = r_q[QW-1] ? {1'b0, {(QW-1){1'b1}}} : r_q;
    assign w_neg  = r_q[QW-1] ? {1'b1, {(QW-1){1'b0}}} : (~r_q + QW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor <= ElemW'(1);
            r_dot   <= '0;
            r_maga  <= '0;
            r_magb  <= '0;
            r_last  <= 1'b0;
        end else begin
            if (i_cfg_we) r_floor <= i_cfg_floor;
            if (i_cmd.load) r_last <= i_last;
            if (i_cmd.acc) begin
                if (w_dsum[DotW] != w_dsum[DotW-1])
                    r_dot <= w_dsum[DotW] ? {1'b1, {(DotW-1){1'b0}}}
                                          : {1'b0, {(DotW-1){1'b1}}};
                else
                    r_dot <= w_dsum[DotW-1:0];
                r_maga <= w_asum[MagW] ? {MagW{1'b1}} : w_asum[MagW-1:0];
                r_magb <= w_bsum[MagW] ? {MagW{1'b1}} : w_bsum[MagW-1:0];
            end else if (i_cmd.finish) begin
                r_dot  <= '0;
                r_maga <= '0;
                r_magb <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fsq <= r_floor * r_floor;
        if (i_cmd.load) begin
            r_a <= i_elem_a;
            r_b <= i_elem_b;
        end
        if (i_cmd.prod) begin
            r_pab <= r_a * r_b;
            r_paa <= r_a * r_a;
            r_pbb <= r_b * r_b;
        end
        if (i_cmd.mul_init) begin
            r_p    <= '0;
            r_d    <= '0;
            r_mdot <= r_dot[DotW-1] ? DotW'(-r_dot) : DotW'(r_dot);
        end
        if (i_cmd.mul_step) begin
            if (i_cmd.idx < CntW'(MagW) && r_magb[i_cmd.idx])
                r_p <= r_p + (ProdW'(r_maga) << i_cmd.idx);
            if (r_mdot[i_cmd.idx])
                r_d <= r_d + (DsqW'(r_mdot) << i_cmd.idx);
        end
        if (i_cmd.srt_init) begin
            r_s <= '0;
            r_t <= '0;
            r_q <= '0;
        end
        if (i_cmd.srt_a) begin
            // (q + 2^k)^2 P - q^2 P = 2^(k+1) qP + 2^(2k) P
            r_u <= (r_t << ({1'b0, w_k} + 5'd1)) + (w_pw << {w_k, 1'b0});
            r_degen <= (r_p == '0) || (r_p < ProdW'(r_fsq));
        end
        if (i_cmd.srt_b && w_cand <= w_dd) begin
            r_s      <= w_cand;
            r_t      <= r_t + (w_pw << w_k);
            r_q[w_k] <= 1'b1;
        end
        if (i_cmd.finish) begin
            o_degenerate <= r_degen;
            if (r_degen)
                o_similarity <= '0;
            else
                o_similarity <= r_dot[DotW-1] ? w_neg : w_pos;
        end
    end
endmodule

### hw/rtl/cosine_similarity_engine_unit.sv
// ----------------------------------------------------------------------------
// cosine_similarity_engine_unit
// Streaming cosine similarity of two Q1.15 vectors, one element pair a beat.
//
//  channel  | valid / ready            | payload
//  ---------+--------------------------+-------------------------------------
//  input    | i_valid / o_ready        | i_elem_a, i_elem_b, i_last
//  output   | o_valid / i_ready        | o_similarity, o_degenerate
//  config   | i_cfg_valid / o_cfg_ready| i_cfg_denominator_floor
//
// A beat without last goes through capture, product and accumulate. A last
// beat then adds the serial shift-add multiply and the root search, which
// forms the result one bit at a time, increment then compare and commit.
// Reset is synchronous, active low; floor resets to 1, accumulators to zero.
// A finished result waits in the output register; the next vector streams in
// meanwhile, and only a second result stalls until the first is taken.
// ----------------------------------------------------------------------------
module cosine_similarity_engine_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [cse_pkg::ElemW-1:0] i_elem_a,
    input  logic signed [cse_pkg::ElemW-1:0] i_elem_b,
    input  logic                          i_last,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [cse_pkg::ElemW-1:0] o_similarity,
    output logic                          o_degenerate,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [cse_pkg::ElemW-1:0]     i_cfg_denominator_floor
);
    import cse_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    assign o_cfg_ready = 1'b1;

    cse_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    cse_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_elem_a     (i_elem_a),
        .i_elem_b     (i_elem_b),
        .i_last       (i_last),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_floor  (i_cfg_denominator_floor),
        .o_similarity (o_similarity),
        .o_degenerate (o_degenerate)
    );
endmodule
